// ===== hw/rtl/mts_pkg.sv =====
// Shared types and constants for the minimum-tracking stack.
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 11;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    req_type_e                req_type;
    logic signed [ValueW-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [ValueW-1:0] top_value;
    logic signed [ValueW-1:0] least_value;
    logic [CountW-1:0]        entry_count;
    logic                     is_empty;
    status_e                  status;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/min_tracking_stack_unit.sv =====
// Top level of the minimum-tracking stack: sequencer, top caches and the two stack memories.
`timescale 1ns / 1ps
`default_nettype none

// A push, a refused request or an emptying pop puts its result in the output register on
// acceptance, or in pend_q while that register is occupied; other pops first read the new
// tops from the memories (registered read) and end in ST_READ. Pushes are taken one per
// cycle while results drain; a reading pop holds off the next item until its tops are back.
// Any item is accepted once the sequencer is idle, even while a result still waits to be
// taken. Reset clears both counters and the handshake state; the memories need no clearing.

module min_tracking_stack_unit #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire mts_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output mts_pkg::rsp_t      out_data_o
);

  import mts_pkg::*;

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);

  // The sequencer is idle, waits for the memory read of a pop, or holds a finished
  // result because the output register is still occupied.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_HOLD
  } state_e;

  state_e state_q, state_d;

  // Cached tops of both stacks and their fill counts.
  logic [CntW-1:0]   dcnt_q, dcnt_d, mcnt_q, mcnt_d;
  logic [ValueW-1:0] dtop_q, dtop_d, mtop_q, mtop_d;

  rsp_t pend_q, out_q, res;
  logic out_valid_q, res_valid;

  // Memory ports.
  logic              dwe, mwe, dre, mre;
  logic [AddrW-1:0]  dwaddr, mwaddr, draddr, mraddr;
  logic [ValueW-1:0] drdata, mrdata;

  logic [CntW-1:0] dcnt_m2, mcnt_m1, mcnt_m2;

  logic accept, out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign dcnt_m2 = dcnt_q - CntW'(2);
  assign mcnt_m1 = mcnt_q - CntW'(1);
  assign mcnt_m2 = mcnt_q - CntW'(2);

  mts_ram #(.Width(ValueW), .Depth(STACK_DEPTH)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dwe),
    .waddr_i (dwaddr),
    .wdata_i (in_data_i.push_value),
    .re_i    (dre),
    .raddr_i (draddr),
    .rdata_o (drdata)
  );

  mts_ram #(.Width(ValueW), .Depth(STACK_DEPTH)) u_min_ram (
    .clk_i   (clk_i),
    .we_i    (mwe),
    .waddr_i (mwaddr),
    .wdata_i (in_data_i.push_value),
    .re_i    (mre),
    .raddr_i (mraddr),
    .rdata_o (mrdata)
  );

  // Request processing. A push writes the memories at the current counts and updates the
  // caches at once. A pop that leaves values behind reads the entry below the old data top
  // and the new minimum top, refreshing the caches from the read data in the following cycle.
  always_comb begin
    state_d   = state_q;
    dcnt_d    = dcnt_q;
    mcnt_d    = mcnt_q;
    dtop_d    = dtop_q;
    mtop_d    = mtop_q;
    dwe       = 1'b0;
    mwe       = 1'b0;
    dre       = 1'b0;
    mre       = 1'b0;
    dwaddr    = dcnt_q[AddrW-1:0];
    mwaddr    = mcnt_q[AddrW-1:0];
    draddr    = dcnt_m2[AddrW-1:0];
    mraddr    = mcnt_m1[AddrW-1:0];
    res_valid = 1'b0;
    res.status = STATUS_OK;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.req_type == REQ_PUSH) begin
            res_valid = 1'b1;
            if (dcnt_q == CntW'(STACK_DEPTH)) begin
              res.status = STATUS_OVERFLOW;
            end else begin
              dwe    = 1'b1;
              dcnt_d = dcnt_q + CntW'(1);
              dtop_d = in_data_i.push_value;
              // Equal values are pushed too, so that duplicates of the minimum survive pops.
              if (mcnt_q == '0 || $signed(in_data_i.push_value) <= $signed(mtop_q)) begin
                mwe    = 1'b1;
                mcnt_d = mcnt_q + CntW'(1);
                mtop_d = in_data_i.push_value;
              end
            end
          end else begin
            if (dcnt_q == '0) begin
              res_valid  = 1'b1;
              res.status = STATUS_UNDERFLOW;
            end else begin
              dcnt_d = dcnt_q - CntW'(1);
              // When the minimum leaves, the new minimum sits one entry further down.
              if (mcnt_q != '0 && mtop_q == dtop_q) begin
                mcnt_d = mcnt_q - CntW'(1);
                mraddr = mcnt_m2[AddrW-1:0];
              end
              if (dcnt_d == '0) begin
                res_valid = 1'b1;
              end else begin
                dre     = 1'b1;
                mre     = 1'b1;
                state_d = ST_READ;
              end
            end
          end
        end
      end
      ST_READ: begin
        dtop_d    = drdata;
        mtop_d    = mrdata;
        res_valid = 1'b1;
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res.entry_count = CountW'(dcnt_d);
    res.is_empty    = (dcnt_d == '0);
    res.top_value   = (dcnt_d == '0) ? '0 : dtop_d;
    res.least_value = (dcnt_d == '0) ? '0 : mtop_d;

    // A result that cannot enter the output register is parked until it can.
    if (res_valid) begin
      state_d = out_free ? ST_IDLE : ST_HOLD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dcnt_q      <= '0;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dcnt_q  <= dcnt_d;
      mcnt_q  <= mcnt_d;
      if (res_valid && out_free) begin
        out_valid_q <= 1'b1;
      end else if (state_q == ST_HOLD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    dtop_q <= dtop_d;
    mtop_q <= mtop_d;
    if (res_valid) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        pend_q <= res;
      end
    end else if (state_q == ST_HOLD && out_free) begin
      out_q <= pend_q;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mts_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module mts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
